[hdl/gcbs_pkg.sv]
package gcbs_pkg;

    // Display geometry
    localparam int MAX_PAGES      = 8;
    localparam int SCREEN_COLUMNS = 128;
    localparam int COL_W          = $clog2(SCREEN_COLUMNS);

    // Register indexes on the configuration port
    localparam logic [2:0] REG_ENABLED     = 3'd0;
    localparam logic [2:0] REG_FIRST_COL   = 3'd1;
    localparam logic [2:0] REG_FIRST_PAGE  = 3'd2;
    localparam logic [2:0] REG_PAGE_COUNT  = 3'd3;
    localparam logic [2:0] REG_WIDTH       = 3'd4;
    localparam logic [2:0] REG_COL_OPCODE  = 3'd5;
    localparam logic [2:0] REG_PAGE_OPCODE = 3'd6;

    // Error codes carried with each result beat
    localparam logic [1:0] ERR_NONE     = 2'd0;
    localparam logic [1:0] ERR_DISABLED = 2'd1;
    localparam logic [1:0] ERR_RANGE    = 2'd2;

    // Beat sequence of one sample
    localparam logic [2:0] BEAT_COL_OP    = 3'd0;
    localparam logic [2:0] BEAT_COL_START = 3'd1;
    localparam logic [2:0] BEAT_COL_END   = 3'd2;
    localparam logic [2:0] BEAT_PAGE_OP   = 3'd3;
    localparam logic [2:0] BEAT_PAGE_FIRST = 3'd4;
    localparam logic [2:0] BEAT_PAGE_LAST = 3'd5;
    localparam logic [2:0] BEAT_DATA      = 3'd6;

    typedef struct packed {
        logic       enabled;
        logic [6:0] first_column;
        logic [2:0] first_page;
        logic [3:0] page_count;
        logic [7:0] width;
        logic [7:0] col_opcode;
        logic [7:0] page_opcode;
    } cfg_t;

    // Decoded sample, held while its beats go out
    typedef struct packed {
        logic [1:0] err;
        logic [7:0] column;
        logic [3:0] last_page;
        logic [2:0] pages_m1;
        logic [5:0] row;
    } item_t;

endpackage

[hdl/graph_column_byte_stream.sv]
// Turns one graph sample (column index, row value) into the byte run that
// redraws that column on a page-addressed monochrome display controller:
// column opcode, column, column, page opcode, first page, last page, then one
// bit-reversed pixel byte per graph page, top page first, with tlast on the
// final byte. A sample while disabled, or with a column at or beyond the graph
// width, gives a single beat with out_byte 0 and an error code. The output
// register issues one beat per cycle while m_tready is high: a good sample gives
// 6 + pages beats (7 to 14), an error sample one. The next sample is taken in the
// cycle its predecessor's last beat is loaded, so runs have no gaps. Configuration
// must be written only while no sample is in flight; the block does not enforce it.
module graph_column_byte_stream (
    input  logic        clk,
    input  logic        rst_n,
    // configuration write port
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    // sample input
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // column_index[6:0], sample_value[14:7], zero pad
    // byte output
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // out_byte[7:0], error_code[9:8], zero pad
    output logic        m_tuser,   // is_data
    output logic        m_tlast
);
    import gcbs_pkg::*;

    cfg_t       cfg;
    item_t      item;
    logic [7:0] out_byte;
    logic [1:0] error_code;

    gcbs_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    gcbs_decode u_decode (
        .cfg          (cfg),
        .column_index (s_tdata[6:0]),
        .sample_value (s_tdata[14:7]),
        .item         (item)
    );

    gcbs_emit u_emit (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_in    (item),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .out_byte   (out_byte),
        .is_data    (m_tuser),
        .last_byte  (m_tlast),
        .error_code (error_code),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready)
    );

    assign m_tdata = {6'd0, error_code, out_byte};

endmodule

[hdl/gcbs_cfg.sv]
module gcbs_cfg (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [7:0]         cfg_wdata,
    output gcbs_pkg::cfg_t     cfg
);
    import gcbs_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Decode the register index and merge the write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (cfg_addr)
                REG_ENABLED:     cfg_next.enabled      = cfg_wdata[0];
                REG_FIRST_COL:   cfg_next.first_column = cfg_wdata[6:0];
                REG_FIRST_PAGE:  cfg_next.first_page   = cfg_wdata[2:0];
                REG_PAGE_COUNT:  cfg_next.page_count   = cfg_wdata[3:0];
                REG_WIDTH:       cfg_next.width        = cfg_wdata;
                REG_COL_OPCODE:  cfg_next.col_opcode   = cfg_wdata;
                REG_PAGE_OPCODE: cfg_next.page_opcode  = cfg_wdata;
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enabled      <= 1'b0;
            cfg_reg.first_column <= 7'd3;
            cfg_reg.first_page   <= 3'd0;
            cfg_reg.page_count   <= 4'd1;
            cfg_reg.width        <= 8'd1;
            cfg_reg.col_opcode   <= 8'd33;
            cfg_reg.page_opcode  <= 8'd34;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hdl/gcbs_decode.sv]
module gcbs_decode (
    input  gcbs_pkg::cfg_t  cfg,
    input  logic [6:0]      column_index,
    input  logic [7:0]      sample_value,
    output gcbs_pkg::item_t item
);
    import gcbs_pkg::*;

    logic [3:0] pages;
    logic [2:0] pages_m1;
    logic [5:0] row_limit;
    logic [7:0] col_sum;

    // Clamp the page count into one to MAX_PAGES
    always_comb
    begin
        if (cfg.page_count == 4'd0)
            pages = 4'd1;
        else if (cfg.page_count > 4'(MAX_PAGES))
            pages = 4'(MAX_PAGES);
        else
            pages = cfg.page_count;
    end

    assign pages_m1  = 3'(pages - 4'd1);
    assign row_limit = {pages_m1, 3'b111};
    assign col_sum   = {1'b0, cfg.first_column} + {1'b0, column_index};

    // Build the decoded sample
    always_comb
    begin
        if (!cfg.enabled)
            item.err = ERR_DISABLED;
        else if ({1'b0, column_index} >= cfg.width)
            item.err = ERR_RANGE;
        else
            item.err = ERR_NONE;

        // Wrap the screen column around the screen width
        item.column    = 8'(col_sum[COL_W-1:0]);
        item.last_page = {1'b0, cfg.first_page} + pages - 4'd1;
        item.pages_m1  = pages_m1;

        // Saturate the row at the graph height
        if (sample_value > {2'b00, row_limit})
            item.row = row_limit;
        else
            item.row = sample_value[5:0];
    end

endmodule

[hdl/gcbs_emit.sv]
module gcbs_emit (
    input  logic            clk,
    input  logic            rst_n,
    input  gcbs_pkg::cfg_t  cfg,
    input  gcbs_pkg::item_t item_in,
    input  logic            in_valid,
    output logic            in_ready,
    output logic [7:0]      out_byte,
    output logic            is_data,
    output logic            last_byte,
    output logic [1:0]      error_code,
    output logic            out_valid,
    input  logic            out_ready
);
    import gcbs_pkg::*;

    item_t      item_reg;
    logic       item_valid_reg;
    logic [2:0] beat_reg;
    logic [2:0] page_reg;

    logic       out_valid_reg;
    logic [7:0] byte_reg;
    logic       data_reg;
    logic       last_reg;
    logic [1:0] err_reg;

    logic       load;
    logic       is_err;
    logic       last_beat;
    logic       take;
    logic [7:0] byte_next;
    logic       data_next;

    assign load      = item_valid_reg && (!out_valid_reg || out_ready);
    assign is_err    = item_reg.err != ERR_NONE;
    assign last_beat = is_err || (beat_reg == BEAT_DATA && page_reg == 3'd0);
    assign in_ready  = !item_valid_reg || (load && last_beat);
    assign take      = in_valid && in_ready;

    // Select the byte for the current beat
    always_comb
    begin
        data_next = 1'b0;
        if (is_err)
        begin
            byte_next = 8'd0;
        end
        else
        begin
            case (beat_reg)
                BEAT_COL_OP:     byte_next = cfg.col_opcode;
                BEAT_COL_START:  byte_next = item_reg.column;
                BEAT_COL_END:    byte_next = item_reg.column;
                BEAT_PAGE_OP:    byte_next = cfg.page_opcode;
                BEAT_PAGE_FIRST: byte_next = {5'd0, cfg.first_page};
                BEAT_PAGE_LAST:  byte_next = {4'd0, item_reg.last_page};
                default:
                begin
                    // Pixel byte, bit-reversed: the lit row sits at bit 7 - row[2:0]
                    data_next = 1'b1;
                    if (page_reg == item_reg.row[5:3])
                        byte_next = 8'h80 >> item_reg.row[2:0];
                    else
                        byte_next = 8'd0;
                end
            endcase
        end
    end

    // Hold the sample and step through its beats
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            beat_reg       <= BEAT_COL_OP;
            page_reg       <= 3'd0;
        end
        else if (take)
        begin
            item_valid_reg <= 1'b1;
            beat_reg       <= BEAT_COL_OP;
            page_reg       <= item_in.pages_m1;
        end
        else if (load)
        begin
            if (last_beat)
                item_valid_reg <= 1'b0;
            else if (beat_reg != BEAT_DATA)
                beat_reg <= beat_reg + 3'd1;
            else
                page_reg <= page_reg - 3'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= item_in;
    end

    // Output register: load a beat when the slot is free or being drained
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg <= byte_next;
            data_reg <= data_next;
            last_reg <= last_beat;
            err_reg  <= item_reg.err;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = byte_reg;
    assign is_data    = data_reg;
    assign last_byte  = last_reg;
    assign error_code = err_reg;

endmodule

[verif/tb_graph_column_byte_stream.sv]
module tb_graph_column_byte_stream;
    import gcbs_pkg::*;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int WATCHDOG_LIMIT  = 3000;
    localparam int PHASE_SAMPLES   = 32;
    localparam int RANDOM_PHASES   = 8;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [2:0]  cfg_addr;
    logic [7:0]  cfg_wdata;
    logic        s_tvalid;
    logic        s_tready;
    logic [15:0] s_tdata;
    logic        m_tvalid;
    logic        m_tready;
    logic [15:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;

    // pacing controls shared by the sender, the receiver and the main sequence, and the watchdog's idle count
    bit calm_send;
    bit calm_recv;
    bit stall_request;
    int idle_cycles;

    typedef struct {
        logic [7:0] out_byte;
        logic       is_data;
        logic       last_byte;
        logic [1:0] error_code;
    } column_beat_t;

    // Tracks the register copy and the byte runs still owed by the block
    class column_run_board;
        bit       enabled;
        bit [6:0] first_column;
        bit [2:0] first_page;
        bit [3:0] page_count;
        bit [7:0] width;
        bit [7:0] col_opcode;
        bit [7:0] page_opcode;
        column_beat_t pending_beats[$];
        int failures;

        function new();
            enabled      = 1'b0;
            first_column = 7'd3;
            first_page   = 3'd0;
            page_count   = 4'd1;
            width        = 8'd1;
            col_opcode   = 8'd33;
            page_opcode  = 8'd34;
            failures     = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [7:0] value);
            case (idx)
                REG_ENABLED:     enabled      = value[0];
                REG_FIRST_COL:   first_column = value[6:0];
                REG_FIRST_PAGE:  first_page   = value[2:0];
                REG_PAGE_COUNT:  page_count   = value[3:0];
                REG_WIDTH:       width        = value;
                REG_COL_OPCODE:  col_opcode   = value;
                REG_PAGE_OPCODE: page_opcode  = value;
                default: ;
            endcase
        endfunction

        function void push_beat(logic [7:0] b, logic d, logic l, logic [1:0] e);
            column_beat_t beat;
            beat.out_byte   = b;
            beat.is_data    = d;
            beat.last_byte  = l;
            beat.error_code = e;
            pending_beats.push_back(beat);
        endfunction

        // Work out the whole byte run for one accepted sample
        function void note_sample(logic [6:0] idx, logic [7:0] value);
            int pages;
            int row;
            int screen_col;
            if (!enabled)
            begin
                push_beat(8'd0, 1'b0, 1'b1, ERR_DISABLED);
                return;
            end
            if ({1'b0, idx} >= width)
            begin
                push_beat(8'd0, 1'b0, 1'b1, ERR_RANGE);
                return;
            end
            pages = (page_count == 0) ? 1 : (page_count > MAX_PAGES ? MAX_PAGES : page_count);
            screen_col = (int'(first_column) + int'(idx)) % SCREEN_COLUMNS;
            row = (int'(value) > pages * 8 - 1) ? pages * 8 - 1 : int'(value);
            push_beat(col_opcode, 1'b0, 1'b0, ERR_NONE);
            push_beat(8'(screen_col), 1'b0, 1'b0, ERR_NONE);
            push_beat(8'(screen_col), 1'b0, 1'b0, ERR_NONE);
            push_beat(page_opcode, 1'b0, 1'b0, ERR_NONE);
            push_beat(8'(first_page), 1'b0, 1'b0, ERR_NONE);
            push_beat(8'(int'(first_page) + pages - 1), 1'b0, 1'b0, ERR_NONE);
            // top page first; the lit row sits bit-reversed within its page
            for (int k = pages - 1; k >= 0; k--)
                push_beat((row / 8 == k) ? (8'h80 >> (row % 8)) : 8'h00,
                          1'b1, k == 0, ERR_NONE);
        endfunction

        function void check_beat(logic [7:0] out_byte, logic is_data, logic last_byte,
                                 logic [1:0] error_code);
            column_beat_t want;
            if (pending_beats.size() == 0)
            begin
                $error("unexpected beat: out_byte %0h error_code %0d", out_byte, error_code);
                failures++;
                return;
            end
            want = pending_beats.pop_front();
            if (out_byte !== want.out_byte)
            begin
                $error("out_byte: expected %0h, actual %0h", want.out_byte, out_byte);
                failures++;
            end
            if (is_data !== want.is_data)
            begin
                $error("is_data: expected %0d, actual %0d", want.is_data, is_data);
                failures++;
            end
            if (last_byte !== want.last_byte)
            begin
                $error("last_byte: expected %0d, actual %0d", want.last_byte, last_byte);
                failures++;
            end
            if (error_code !== want.error_code)
            begin
                $error("error_code: expected %0d, actual %0d", want.error_code, error_code);
                failures++;
            end
        endfunction

        function int pending();
            return pending_beats.size();
        endfunction
    endclass

    column_run_board board;

    graph_column_byte_stream dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),   // column_index[6:0], sample_value[14:7], zero pad
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),   // out_byte[7:0], error_code[9:8], zero pad
        .m_tuser   (m_tuser),   // is_data
        .m_tlast   (m_tlast)
    );

    // Free-running clock
    initial clk = 1'b0;
    always #6 clk = ~clk;

    // Write one register at a falling edge and mirror it in the board
    task automatic write_reg(input logic [2:0] idx, input logic [7:0] value);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
        board.set_reg(idx, value);
    endtask

    task automatic load_settings(input logic en, input logic [6:0] fc, input logic [2:0] fp,
                                 input logic [3:0] pc, input logic [7:0] w,
                                 input logic [7:0] cop, input logic [7:0] pop);
        write_reg(REG_ENABLED, {7'd0, en});
        write_reg(REG_FIRST_COL, {1'b0, fc});
        write_reg(REG_FIRST_PAGE, {5'd0, fp});
        write_reg(REG_PAGE_COUNT, {4'd0, pc});
        write_reg(REG_WIDTH, w);
        write_reg(REG_COL_OPCODE, cop);
        write_reg(REG_PAGE_OPCODE, pop);
    endtask

    // Offer one sample, with random gaps unless the sender is kept calm
    task automatic send_sample(input logic [6:0] idx, input logic [7:0] value);
        while (!calm_send && $urandom_range(99) < 12)
        begin
            @(negedge clk);
            s_tvalid <= 1'b0;
        end
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, value, idx};
        do @(posedge clk); while (!s_tready);
        board.note_sample(idx, value);
    endtask

    // Drop valid and wait for every owed beat, then let the output register settle
    task automatic drain_runs();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (board.pending() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic int biased_pick(int maxv);
        int r;
        r = $urandom_range(3);
        if (r == 0) return 0;
        if (r == 1) return maxv;
        return $urandom_range(maxv);
    endfunction

    // Receiver: random back-pressure, plus a long hold-off on request
    initial
    begin
        m_tready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (stall_request)
            begin
                m_tready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(negedge clk);
                stall_request = 1'b0;
            end
            m_tready <= calm_recv ? 1'b1 : ($urandom_range(99) >= 12);
        end
    end

    // Check every output beat
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            board.check_beat(m_tdata[7:0], m_tuser, m_tlast, m_tdata[9:8]);
    end

    // Abort when the stream stops moving
    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("graph_column_byte_stream verification failed");
            $finish;
        end
    end

    initial
    begin
        int         phase;
        int         n;
        int         rows;
        logic [3:0] pc;
        logic [7:0] w;
        logic [6:0] idx;
        logic [7:0] value;

        board         = new();
        calm_send     = 1'b0;
        calm_recv     = 1'b0;
        stall_request = 1'b0;
        cfg_we        = 1'b0;
        cfg_addr      = 3'd0;
        cfg_wdata     = 8'd0;
        s_tvalid      = 1'b0;
        s_tdata       = 16'd0;
        rst_n         = 1'b0;
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // out of reset the block is disabled; that beats a bad column too
        send_sample(7'd0, 8'd0);
        send_sample(7'd127, 8'd255);
        drain_runs();

        // eight pages at the far corner: column wrap, last page past the bottom,
        // clamp to the bottom row and the page boundaries at rows 7/8 and 55/56
        load_settings(1'b1, 7'd127, 3'd7, 4'd8, 8'd128, 8'd0, 8'd255);
        send_sample(7'd0, 8'd0);
        send_sample(7'd127, 8'd255);
        send_sample(7'd1, 8'd63);
        send_sample(7'd2, 8'd64);
        send_sample(7'd3, 8'd7);
        send_sample(7'd4, 8'd8);
        send_sample(7'd5, 8'd56);
        send_sample(7'd6, 8'd55);
        drain_runs();

        // zero page count acts as one page; a column equal to the width is rejected
        load_settings(1'b1, 7'd0, 3'd0, 4'd0, 8'd5, 8'h21, 8'h22);
        send_sample(7'd4, 8'd8);
        send_sample(7'd5, 8'd0);
        send_sample(7'd127, 8'd3);
        send_sample(7'd0, 8'd7);
        drain_runs();

        // oversized page count acts as eight; width beyond the screen
        load_settings(1'b1, 7'd64, 3'd3, 4'd15, 8'd255, 8'd255, 8'd0);
        send_sample(7'd127, 8'd200);
        send_sample(7'd0, 8'd1);
        drain_runs();

        // zero width rejects every column, unless disabled wins first
        load_settings(1'b1, 7'd64, 3'd3, 4'd9, 8'd0, 8'd255, 8'd0);
        send_sample(7'd0, 8'd0);
        drain_runs();
        write_reg(REG_ENABLED, 8'd0);
        send_sample(7'd9, 8'd9);
        drain_runs();

        // random settings per phase, random samples within each
        for (phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pc = (phase == 2) ? 4'd8 : 4'(biased_pick(15));
            w  = (phase == 2) ? 8'd128 : 8'(biased_pick(255));
            load_settings((phase == 2) || ($urandom_range(9) != 0),
                          7'(biased_pick(127)), 3'(biased_pick(7)), pc, w,
                          8'(biased_pick(255)), 8'(biased_pick(255)));
            rows = (pc == 0) ? 8 : ((pc > MAX_PAGES) ? MAX_PAGES * 8 : pc * 8);
            calm_send = (phase == 2) || (phase == 4);
            calm_recv = (phase == 4);
            // long receiver hold-off while samples keep coming
            if (phase == 2)
                stall_request = 1'b1;
            for (n = 0; n < PHASE_SAMPLES; n++)
            begin
                if (w != 0 && $urandom_range(4) != 0)
                    idx = 7'($urandom_range((w > 128) ? 127 : w - 1));
                else
                    idx = 7'($urandom_range(127));
                if ($urandom_range(1) == 0)
                    value = 8'($urandom_range(rows - 1));
                else
                    value = 8'($urandom_range(255));
                send_sample(idx, value);
            end
            drain_runs();
        end

        calm_send = 1'b0;
        calm_recv = 1'b0;
        repeat (16) @(posedge clk);
        if (board.failures == 0 && board.pending() == 0)
            $display("graph_column_byte_stream verification clean");
        else
            $display("graph_column_byte_stream verification failed");
        $finish;
    end

endmodule
